>>> hdl/pkwql_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pkwql_pkg;

    // Key table geometry
    localparam int TABLE_ENTRIES = 16;

    // Field widths
    localparam int KEY_W      = 32;
    localparam int LEN_W      = 16;
    localparam int SEC_W      = 32;
    localparam int NSEC_W     = 30;
    localparam int COUNT_W    = 32;
    localparam int QUOTA_W    = 32;
    localparam int WINDOW_W   = 8;
    localparam int OVERHEAD_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [QUOTA_W-1:0]    QUOTA_RESET    = QUOTA_W'(10240);
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = WINDOW_W'(1);
    localparam logic [OVERHEAD_W-1:0] OVERHEAD_RESET = OVERHEAD_W'(2);

    // Saturation limit for sums and drop counts
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUOTA    = 2'd0,
        CFG_WINDOW   = 2'd1,
        CFG_OVERHEAD = 2'd2
    } cfg_reg_t;

    // One key table entry
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] sum;
        logic [COUNT_W-1:0] drops;
        logic [SEC_W-1:0]   start_sec;
        logic [NSEC_W-1:0]  start_nsec;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/per_key_window_quota_limiter_core.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   is_app_log, domain_id, msg_len, time_sec, time_nsec
// out       output     out_valid / out_stall drop, reported_drops, untracked
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; an input is held in the input register,
// then the table lookup and update land in the result register.
// All 16 table entries are matched in parallel, so each event is decided without a search pass.
// Reset clears the entry valid bits and loads the register defaults; no clearing pass.
// A stalled result holds the input register, which raises in_stall in the same cycle.
// cfg_ready is always high; writes to an index beyond the register list are ignored.
`timescale 1ns / 1ps
`default_nettype none

module per_key_window_quota_limiter_core
(
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,

    input  wire  logic                              in_valid,
    output logic                                    in_stall,
    input  wire  logic                              is_app_log,
    input  wire  logic [pkwql_pkg::KEY_W-1:0]       domain_id,
    input  wire  logic [pkwql_pkg::LEN_W-1:0]       msg_len,
    input  wire  logic [pkwql_pkg::SEC_W-1:0]       time_sec,
    input  wire  logic [pkwql_pkg::NSEC_W-1:0]      time_nsec,

    output logic                                    out_valid,
    input  wire  logic                              out_stall,
    output logic                                    drop,
    output logic [pkwql_pkg::COUNT_W-1:0]           reported_drops,
    output logic                                    untracked,

    input  wire  logic                              cfg_valid,
    output logic                                    cfg_ready,
    input  wire  logic [pkwql_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  logic [pkwql_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int N = pkwql_pkg::TABLE_ENTRIES;

    // Configuration registers
    logic [pkwql_pkg::QUOTA_W-1:0]    quota_reg;
    logic [pkwql_pkg::WINDOW_W-1:0]   window_reg;
    logic [pkwql_pkg::OVERHEAD_W-1:0] overhead_reg;

    // Input register
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic                              s1_app_reg;
    logic [pkwql_pkg::KEY_W-1:0]       s1_key_reg;
    logic [pkwql_pkg::LEN_W-1:0]       s1_len_reg;
    logic [pkwql_pkg::SEC_W-1:0]       s1_sec_reg;
    logic [pkwql_pkg::NSEC_W-1:0]      s1_nsec_reg;

    // Key table
    logic [N-1:0]                      entry_valid_reg;
    logic [N-1:0]                      entry_valid_next;
    pkwql_pkg::entry_t                 entry_reg [N];
    pkwql_pkg::entry_t                 entry_next;

    // Result register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              drop_reg;
    logic                              drop_next;
    logic [pkwql_pkg::COUNT_W-1:0]     rep_drops_reg;
    logic [pkwql_pkg::COUNT_W-1:0]     rep_drops_next;
    logic                              untracked_reg;
    logic                              untracked_next;

    // Decision logic
    logic                              in_accept;
    logic                              proc_fire;
    logic [pkwql_pkg::LEN_W:0]         len_diff;
    logic [pkwql_pkg::LEN_W-1:0]       payload;
    logic [N-1:0]                      hit_vec;
    logic [N-1:0]                      free_vec;
    logic [N-1:0]                      free_oh;
    logic [N-1:0]                      wr_vec;
    logic                              any_hit;
    logic                              any_free;
    pkwql_pkg::entry_t                 hit_entry;
    logic [pkwql_pkg::SEC_W:0]         end_sec;
    logic                              ended;
    logic [pkwql_pkg::COUNT_W:0]       sum_add;
    logic [pkwql_pkg::COUNT_W-1:0]     sum_sat;
    logic [pkwql_pkg::COUNT_W-1:0]     drops_sat;

    // Advance when the result register is empty or being drained
    assign proc_fire = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !proc_fire;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Payload: length minus overhead, clamped at zero
    assign len_diff = {1'b0, s1_len_reg} - {{(pkwql_pkg::LEN_W + 1 - pkwql_pkg::OVERHEAD_W){1'b0}},
                                            overhead_reg};
    assign payload  = len_diff[pkwql_pkg::LEN_W] ? '0 : len_diff[pkwql_pkg::LEN_W-1:0];

    // Match all entries in parallel; pick the lowest free entry
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            hit_vec[i] = entry_valid_reg[i] && (entry_reg[i].key == s1_key_reg);
        end
    end

    assign free_vec = ~entry_valid_reg;
    assign free_oh  = free_vec & (~free_vec + N'(1));
    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;

    // Select the matching entry (keys are unique, so at most one hit)
    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < N; i++)
        begin
            hit_entry = hit_entry | ({$bits(pkwql_pkg::entry_t){hit_vec[i]}} & entry_reg[i]);
        end
    end

    // Window end and saturating updates
    assign end_sec   = {1'b0, hit_entry.start_sec}
                     + {{(pkwql_pkg::SEC_W + 1 - pkwql_pkg::WINDOW_W){1'b0}}, window_reg};
    assign ended     = ({1'b0, s1_sec_reg} > end_sec)
                     || (({1'b0, s1_sec_reg} == end_sec) && (s1_nsec_reg > hit_entry.start_nsec));
    assign sum_add   = {1'b0, hit_entry.sum}
                     + {{(pkwql_pkg::COUNT_W + 1 - pkwql_pkg::LEN_W){1'b0}}, payload};
    assign sum_sat   = sum_add[pkwql_pkg::COUNT_W] ? pkwql_pkg::COUNT_MAX
                                                   : sum_add[pkwql_pkg::COUNT_W-1:0];
    assign drops_sat = (hit_entry.drops == pkwql_pkg::COUNT_MAX) ? pkwql_pkg::COUNT_MAX
                                                                 : hit_entry.drops + 1'b1;

    // Decide the event and build the entry write
    always_comb
    begin
        entry_next            = hit_entry;
        drop_next             = 1'b0;
        rep_drops_next        = '0;
        untracked_next        = 1'b0;
        wr_vec                = '0;
        if (!s1_app_reg)
        begin
            if (any_hit)
            begin
                wr_vec = hit_vec;
                if (ended)
                begin
                    rep_drops_next        = hit_entry.drops;
                    entry_next.sum        = {{(pkwql_pkg::COUNT_W - pkwql_pkg::LEN_W){1'b0}},
                                             payload};
                    entry_next.drops      = '0;
                    entry_next.start_sec  = s1_sec_reg;
                    entry_next.start_nsec = s1_nsec_reg;
                end
                else if (hit_entry.sum <= quota_reg)
                begin
                    entry_next.sum = sum_sat;
                end
                else
                begin
                    entry_next.drops = drops_sat;
                    drop_next        = 1'b1;
                end
            end
            else if (any_free)
            begin
                wr_vec                = free_oh;
                entry_next.key        = s1_key_reg;
                entry_next.sum        = {{(pkwql_pkg::COUNT_W - pkwql_pkg::LEN_W){1'b0}}, payload};
                entry_next.drops      = '0;
                entry_next.start_sec  = s1_sec_reg;
                entry_next.start_nsec = s1_nsec_reg;
            end
            else
            begin
                untracked_next = 1'b1;
            end
        end
        if (!proc_fire)
        begin
            wr_vec = '0;
        end
    end

    // Control next values
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proc_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        entry_valid_next = entry_valid_reg | wr_vec;
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            quota_reg       <= pkwql_pkg::QUOTA_RESET;
            window_reg      <= pkwql_pkg::WINDOW_RESET;
            overhead_reg    <= pkwql_pkg::OVERHEAD_RESET;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            entry_valid_reg <= entry_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pkwql_pkg::CFG_QUOTA:
                    begin
                        quota_reg <= cfg_data[pkwql_pkg::QUOTA_W-1:0];
                    end
                    pkwql_pkg::CFG_WINDOW:
                    begin
                        window_reg <= cfg_data[pkwql_pkg::WINDOW_W-1:0];
                    end
                    pkwql_pkg::CFG_OVERHEAD:
                    begin
                        overhead_reg <= cfg_data[pkwql_pkg::OVERHEAD_W-1:0];
                    end
                    default:
                    begin
                        quota_reg <= quota_reg;
                    end
                endcase
            end
        end
    end

    // Load the input register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_app_reg  <= is_app_log;
            s1_key_reg  <= domain_id;
            s1_len_reg  <= msg_len;
            s1_sec_reg  <= time_sec;
            s1_nsec_reg <= time_nsec;
        end
    end

    // Write back the updated entry
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (wr_vec[i])
            begin
                entry_reg[i] <= entry_next;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            drop_reg      <= drop_next;
            rep_drops_reg <= rep_drops_next;
            untracked_reg <= untracked_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drop           = drop_reg;
    assign reported_drops = rep_drops_reg;
    assign untracked      = untracked_reg;

`ifndef SYNTHESIS
    // A key is reported untracked only once every entry is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && untracked_reg) |-> (&entry_valid_reg))
        else $error("untracked result while a table entry is free");

    // Entries are never released once claimed
    assert property (@(posedge clk) disable iff (!rst_n)
        ((entry_valid_reg & $past(entry_valid_reg)) == $past(entry_valid_reg)))
        else $error("table entry valid bit cleared");

    // A result is at most one of dropped, restart report or untracked
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(drop_reg && untracked_reg)
                          && !(drop_reg && (rep_drops_reg != '0))
                          && !(untracked_reg && (rep_drops_reg != '0)))
        else $error("conflicting result flags");

    // At most one entry matches a key
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(hit_vec))
        else $error("duplicate key in table");
`endif

endmodule

`default_nettype wire
